// ===== rtl/core/bidirectional_reprojection_inlier_check_assert.svh =====
// Assertion macros shared by the block's checker
`ifndef BIDIRECTIONAL_REPROJECTION_INLIER_CHECK_ASSERT_SVH
`define BIDIRECTIONAL_REPROJECTION_INLIER_CHECK_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BRIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bric: implication check failed");

// next-cycle implication, disabled during reset
`define BRIC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bric: next-cycle check failed");

`endif

// ===== rtl/core/bric_pkg.sv =====
// Shared types and constants of the reprojection inlier check
`default_nettype none
package bric_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int NCOEF          = 24;
    localparam int INV_BASE       = 12;
    localparam int CFG_W          = 31;
    localparam int CFG_AW         = 3;
    localparam int IN_DATA_W      = 296;
    localparam int DIV_NW         = 63;
    localparam int DIV_DW         = 32;

    localparam logic [CFG_W-1:0] FOCAL_RST    = 31'd33554432;
    localparam logic [CFG_W-1:0] CENTER_X_RST = 31'd20971520;
    localparam logic [CFG_W-1:0] CENTER_Y_RST = 31'd15728640;
    localparam logic [31:0]      ERR_SAT      = 32'hFFFF_FFFF;

    localparam logic REQ_POINT = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    typedef enum logic [CFG_AW-1:0] {
        REG_FX1, REG_FY1, REG_CX1, REG_CY1,
        REG_FX2, REG_FY2, REG_CX2, REG_CY2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MUL_COEF, MUL_FOCAL, MUL_SQ
    } t_mul_sel;

    // controller to datapath
    typedef struct packed {
        logic     cap;
        logic     acc_init;
        logic     acc_add;
        logic     tr_store;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        logic     pix_store;
        logic     sq_add;
        logic     err_store;
        logic     out_load;
        logic     tsel;
        logic [1:0] row;
        logic [1:0] col;
        logic     img;
        logic     axis;
        logic     side;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/core/bidirectional_reprojection_inlier_check.sv =====
// Top level of the bidirectional reprojection inlier check
// A load item (tuser high) writes one transform coefficient when it is accepted and
// gives no result. A point item runs the two 3x4 transforms on the shared
// multiplier, then for each image four pixel projections, each through the
// bit-serial 63-bit divider, and its squared error. One item is worked at a time;
// the finished result sits in an output register, so the next item is taken while
// it waits. Configuration is written through i_cfg_we/i_cfg_addr/i_cfg_data; the
// user must write it only while idle, the block does not enforce this.
`default_nettype none
module bidirectional_reprojection_inlier_check #(
    parameter  int MAX_POINTS = bric_pkg::MAX_POINTS_DEF,
    localparam int CW    = $clog2(MAX_POINTS + 1),
    localparam int IW    = $clog2(MAX_POINTS),
    localparam int OUT_W = ((1 + CW + IW + 64 + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // coef_index, coef_value, point_a_x/y/z, point_b_x/y/z, limit_img1, limit_img2
    input  wire logic [bric_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // req_type
    input  wire logic                           s_axis_tuser,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // is_inlier, inlier_count, point_number, err_img1, err_img2
    output logic [OUT_W-1:0]                    m_axis_tdata,
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_we,
    input  wire logic [bric_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [bric_pkg::CFG_W-1:0]     i_cfg_data
);
    import bric_pkg::*;

    t_cmd          cmd;
    t_stat         stat;
    logic          load_we;
    logic          is_inlier, batch_end;
    logic [CW-1:0] inlier_count;
    logic [IW-1:0] point_number;
    logic [31:0]   err1, err2;

    bric_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_ready    (s_axis_tready),
        .o_load_we  (load_we),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    bric_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_load_we    (load_we),
        .i_coef_index (s_axis_tdata[4:0]),
        .i_coef_value (s_axis_tdata[36:5]),
        .i_pa_x       (s_axis_tdata[68:37]),
        .i_pa_y       (s_axis_tdata[100:69]),
        .i_pa_z       (s_axis_tdata[132:101]),
        .i_pb_x       (s_axis_tdata[164:133]),
        .i_pb_y       (s_axis_tdata[196:165]),
        .i_pb_z       (s_axis_tdata[228:197]),
        .i_lim1       (s_axis_tdata[260:229]),
        .i_lim2       (s_axis_tdata[292:261]),
        .i_last       (s_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_out_ack    (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_is_inlier  (is_inlier),
        .o_count      (inlier_count),
        .o_number     (point_number),
        .o_err1       (err1),
        .o_err2       (err2),
        .o_end        (batch_end)
    );

    // result packing
    always_comb begin
        m_axis_tdata                          = '0;
        m_axis_tdata[0]                       = is_inlier;
        m_axis_tdata[CW:1]                    = inlier_count;
        m_axis_tdata[CW+IW:CW+1]              = point_number;
        m_axis_tdata[CW+IW+32:CW+IW+1]        = err1;
        m_axis_tdata[CW+IW+64:CW+IW+33]       = err2;
    end

    assign m_axis_tlast = batch_end;

endmodule
`default_nettype wire

// ===== rtl/core/bric_div.sv =====
// Restoring divider, one quotient bit per cycle
`default_nettype none
module bric_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bric_pkg::DIV_NW-1:0] i_dividend,
    input  wire logic [bric_pkg::DIV_DW-1:0] i_divisor,
    output logic                             o_done,
    output logic [bric_pkg::DIV_NW-1:0]      o_quot
);
    import bric_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_sub;
    logic              q_bit;

    // trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_q[DIV_NW-1]};
        q_bit   = (rem_sh >= {1'b0, r_div});
        rem_sub = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NW-2:0], q_bit};
            r_rem <= rem_sub[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== rtl/core/bric_dp.sv =====
// Datapath: coefficient bank, shared multiplier, divider, error and count
`default_nettype none
module bric_dp #(
    parameter  int MAX_POINTS = bric_pkg::MAX_POINTS_DEF,
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int IW = $clog2(MAX_POINTS)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bric_pkg::t_cmd              i_cmd,
    output bric_pkg::t_stat                  o_stat,
    input  wire logic                        i_load_we,
    input  wire logic [4:0]                  i_coef_index,
    input  wire logic signed [31:0]          i_coef_value,
    input  wire logic signed [31:0]          i_pa_x,
    input  wire logic signed [31:0]          i_pa_y,
    input  wire logic signed [31:0]          i_pa_z,
    input  wire logic signed [31:0]          i_pb_x,
    input  wire logic signed [31:0]          i_pb_y,
    input  wire logic signed [31:0]          i_pb_z,
    input  wire logic [31:0]                 i_lim1,
    input  wire logic [31:0]                 i_lim2,
    input  wire logic                        i_last,
    input  wire logic                        i_cfg_we,
    input  wire logic [bric_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [bric_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_out_ack,
    output logic                             o_valid,
    output logic                             o_is_inlier,
    output logic [CW-1:0]                    o_count,
    output logic [IW-1:0]                    o_number,
    output logic [31:0]                      o_err1,
    output logic [31:0]                      o_err2,
    output logic                             o_end
);
    import bric_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] r_fx1, r_fy1, r_cx1, r_cy1, r_fx2, r_fy2, r_cx2, r_cy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx1 <= FOCAL_RST;    r_fy1 <= FOCAL_RST;
            r_cx1 <= CENTER_X_RST; r_cy1 <= CENTER_Y_RST;
            r_fx2 <= FOCAL_RST;    r_fy2 <= FOCAL_RST;
            r_cx2 <= CENTER_X_RST; r_cy2 <= CENTER_Y_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_FX1: r_fx1 <= i_cfg_data;
                REG_FY1: r_fy1 <= i_cfg_data;
                REG_CX1: r_cx1 <= i_cfg_data;
                REG_CY1: r_cy1 <= i_cfg_data;
                REG_FX2: r_fx2 <= i_cfg_data;
                REG_FY2: r_fy2 <= i_cfg_data;
                REG_CX2: r_cx2 <= i_cfg_data;
                REG_CY2: r_cy2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient bank, slots beyond the bank are dropped
    logic signed [31:0] r_coef [NCOEF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCOEF; k++) r_coef[k] <= '0;
        end else if (i_load_we && (i_coef_index < 5'(NCOEF))) begin
            r_coef[i_coef_index] <= i_coef_value;
        end
    end

    // captured item
    logic signed [31:0] r_pa [3];
    logic signed [31:0] r_pb [3];
    logic signed [31:0] r_ta [3];
    logic signed [31:0] r_tb [3];
    logic [31:0]        r_lim1, r_lim2;
    logic               r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pa[0] <= i_pa_x; r_pa[1] <= i_pa_y; r_pa[2] <= i_pa_z;
            r_pb[0] <= i_pb_x; r_pb[1] <= i_pb_y; r_pb[2] <= i_pb_z;
            r_lim1  <= i_lim1;
            r_lim2  <= i_lim2;
            r_last  <= i_last;
        end
    end

    // coefficient read
    logic [4:0]         coef_addr;
    logic signed [31:0] coef_rd;
    logic signed [31:0] vec_el;

    always_comb begin
        coef_addr = (i_cmd.tsel ? 5'(INV_BASE) : 5'd0) + {1'b0, i_cmd.row, 2'b00}
                    + {3'b000, i_cmd.col};
        coef_rd   = r_coef[coef_addr];
        vec_el    = i_cmd.tsel ? r_pa[i_cmd.col] : r_pb[i_cmd.col];
    end

    // operands of the current pixel projection
    logic signed [31:0] pt [3];
    logic [CFG_W-1:0]   foc, ctr;
    logic signed [31:0] coord;
    logic signed [31:0] z_dir, z_tr;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_cmd.img) pt[k] = i_cmd.side ? r_tb[k] : r_pa[k];
            else            pt[k] = i_cmd.side ? r_ta[k] : r_pb[k];
        end
        coord = i_cmd.axis ? pt[1] : pt[0];
        if (!i_cmd.img) begin
            foc = i_cmd.axis ? r_fy1 : r_fx1;
            ctr = i_cmd.axis ? r_cy1 : r_cx1;
        end else begin
            foc = i_cmd.axis ? r_fy2 : r_fx2;
            ctr = i_cmd.axis ? r_cy2 : r_cx2;
        end
        z_dir = i_cmd.img ? r_pb[2] : r_pa[2];
        z_tr  = i_cmd.img ? r_ta[2] : r_tb[2];
    end

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] r_prod;
    logic [30:0]        r_dval [2];
    logic               r_dbig [2];

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_COEF: begin
                mul_a = {coef_rd[31], coef_rd};
                mul_b = {vec_el[31], vec_el};
            end
            MUL_FOCAL: begin
                mul_a = {2'b00, foc};
                mul_b = {coord[31], coord};
            end
            MUL_SQ: begin
                mul_a = {2'b00, r_dval[i_cmd.axis]};
                mul_b = {2'b00, r_dval[i_cmd.axis]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
    end

    // transform accumulate and saturate
    logic signed [47:0] r_acc;
    logic signed [31:0] acc_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init)
            r_acc <= 48'(signed'(coef_rd[31:4]));
        else if (i_cmd.acc_add)
            r_acc <= r_acc + 48'(signed'(r_prod[63:20]));
    end

    always_comb begin
        if (r_acc > 48'sd2147483647)       acc_sat = 32'sh7FFF_FFFF;
        else if (r_acc < -48'sd2147483648) acc_sat = 32'sh8000_0000;
        else                               acc_sat = r_acc[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tr_store) begin
            if (i_cmd.tsel) r_ta[i_cmd.row] <= acc_sat;
            else            r_tb[i_cmd.row] <= acc_sat;
        end
    end

    // division of f*x by depth, magnitude only
    logic               prod_neg;
    logic [65:0]        prod_mag;
    logic               r_qneg;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quot;

    always_comb begin
        prod_neg = r_prod[65];
        prod_mag = prod_neg ? 66'(-r_prod) : 66'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) r_qneg <= prod_neg;
    end

    bric_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (prod_mag[DIV_NW-1:0]),
        .i_divisor  (z_tr[31:0] & 32'h0 | pt[2][31:0]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // pixel coordinate and absolute difference
    logic signed [64:0] quo_s, pix;
    logic signed [64:0] r_pix0;
    logic signed [65:0] diff;
    logic [65:0]        absd;

    always_comb begin
        quo_s = r_qneg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
        pix   = $signed({34'd0, ctr}) + quo_s;
        diff  = 66'(r_pix0) - 66'(pix);
        absd  = diff[65] ? 66'(-diff) : 66'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_store) begin
            if (!i_cmd.side) begin
                r_pix0 <= pix;
            end else begin
                r_dval[i_cmd.axis] <= absd[30:0];
                r_dbig[i_cmd.axis] <= |absd[65:31];
            end
        end
    end

    // squared error
    logic [62:0] r_sacc;
    logic [46:0] sh;
    logic        err_sat;
    logic [31:0] r_err [2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_add)
            r_sacc <= (i_cmd.axis ? r_sacc : 63'd0) + r_prod[62:0];
    end

    always_comb begin
        sh      = r_sacc[62:16];
        err_sat = (z_dir <= 0) || (z_tr <= 0) || r_dbig[0] || r_dbig[1] || (|sh[46:32]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_store) r_err[i_cmd.img] <= err_sat ? ERR_SAT : sh[31:0];
    end

    // result, running count and position
    logic          inl, fin;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_index;
    logic [CW-1:0] cnt_nx;
    logic          r_valid;

    always_comb begin
        inl    = (r_err[0] < r_lim1) && (r_err[1] < r_lim2);
        cnt_nx = r_count + CW'(inl);
        fin    = r_last || (r_index >= IW'(MAX_POINTS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_index <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
                r_count <= fin ? '0 : cnt_nx;
                r_index <= fin ? '0 : r_index + 1'b1;
            end else if (i_out_ack) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_is_inlier <= inl;
            o_count     <= cnt_nx;
            o_number    <= r_index;
            o_err1      <= r_err[0];
            o_err2      <= r_err[1];
            o_end       <= fin;
        end
    end

    assign o_valid         = r_valid;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_valid || i_out_ack;

endmodule
`default_nettype wire

// ===== rtl/core/bric_ctrl.sv =====
// Controller: sequences transform, projection and error steps per item
`default_nettype none
module bric_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_req_type,
    output logic                 o_ready,
    output logic                 o_load_we,
    output bric_pkg::t_cmd       o_cmd,
    input  wire bric_pkg::t_stat i_stat
);
    import bric_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TR_INIT, S_TR_MUL, S_TR_ADD, S_TR_STORE,
        S_PX_MUL, S_PX_DIV, S_PX_WAIT,
        S_SQ_XM, S_SQ_XA, S_SQ_YM, S_SQ_YA, S_ERR, S_OUT
    } t_state;

    t_state     r_state;
    logic       r_tsel, r_img, r_axis, r_side;
    logic [1:0] r_row, r_col;
    logic       accept;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign o_load_we = accept && (i_req_type == REQ_LOAD);

    // state and step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tsel  <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_img   <= 1'b0;
            r_axis  <= 1'b0;
            r_side  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == REQ_POINT)) begin
                        r_state <= S_TR_INIT;
                        r_tsel  <= 1'b0;
                        r_row   <= '0;
                    end
                end
                S_TR_INIT: begin
                    r_col   <= '0;
                    r_state <= S_TR_MUL;
                end
                S_TR_MUL: r_state <= S_TR_ADD;
                S_TR_ADD: begin
                    if (r_col == 2'd2) begin
                        r_state <= S_TR_STORE;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= S_TR_MUL;
                    end
                end
                S_TR_STORE: begin
                    if (r_row == 2'd2) begin
                        r_row <= '0;
                        if (r_tsel) begin
                            r_img   <= 1'b0;
                            r_axis  <= 1'b0;
                            r_side  <= 1'b0;
                            r_state <= S_PX_MUL;
                        end else begin
                            r_tsel  <= 1'b1;
                            r_state <= S_TR_INIT;
                        end
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_TR_INIT;
                    end
                end
                S_PX_MUL: r_state <= S_PX_DIV;
                S_PX_DIV: r_state <= S_PX_WAIT;
                S_PX_WAIT: begin
                    if (i_stat.div_done) begin
                        r_side <= !r_side;
                        if (r_side) begin
                            r_axis  <= !r_axis;
                            r_state <= r_axis ? S_SQ_XM : S_PX_MUL;
                        end else begin
                            r_state <= S_PX_MUL;
                        end
                    end
                end
                S_SQ_XM: r_state <= S_SQ_XA;
                S_SQ_XA: r_state <= S_SQ_YM;
                S_SQ_YM: r_state <= S_SQ_YA;
                S_SQ_YA: r_state <= S_ERR;
                S_ERR: begin
                    if (r_img) begin
                        r_state <= S_OUT;
                    end else begin
                        r_img   <= 1'b1;
                        r_state <= S_PX_MUL;
                    end
                end
                S_OUT: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_COEF;
        o_cmd.tsel    = r_tsel;
        o_cmd.row     = r_row;
        o_cmd.col     = r_col;
        o_cmd.img     = r_img;
        o_cmd.axis    = r_axis;
        o_cmd.side    = r_side;
        o_cmd.cap     = accept && (i_req_type == REQ_POINT);
        case (r_state)
            S_TR_INIT: begin
                o_cmd.col      = 2'd3;
                o_cmd.acc_init = 1'b1;
            end
            S_TR_MUL:   o_cmd.mul_en   = 1'b1;
            S_TR_ADD:   o_cmd.acc_add  = 1'b1;
            S_TR_STORE: o_cmd.tr_store = 1'b1;
            S_PX_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FOCAL;
            end
            S_PX_DIV:  o_cmd.div_start = 1'b1;
            S_PX_WAIT: o_cmd.pix_store = i_stat.div_done;
            S_SQ_XM: begin
                o_cmd.axis    = 1'b0;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
            end
            S_SQ_XA: begin
                o_cmd.axis   = 1'b0;
                o_cmd.sq_add = 1'b1;
            end
            S_SQ_YM: begin
                o_cmd.axis    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
            end
            S_SQ_YA: begin
                o_cmd.axis   = 1'b1;
                o_cmd.sq_add = 1'b1;
            end
            S_ERR:   o_cmd.err_store = 1'b1;
            S_OUT:   o_cmd.out_load  = i_stat.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/bric_checker.sv =====
// Port-level checker of the reprojection inlier check, with its bind
`default_nettype none
`include "bidirectional_reprojection_inlier_check_assert.svh"
module bric_checker #(
    parameter  int MAX_POINTS = bric_pkg::MAX_POINTS_DEF,
    localparam int CW    = $clog2(MAX_POINTS + 1),
    localparam int IW    = $clog2(MAX_POINTS),
    localparam int OUT_W = ((1 + CW + IW + 64 + 7) / 8) * 8
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             s_axis_tuser,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tlast
);
    import bric_pkg::*;

    // a stalled result holds
    `BRIC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // a point item occupies the block
    `BRIC_ASSERT_NXT(a_point_busy, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_POINT), !s_axis_tready)

    // the first point of a batch counts only itself
    `BRIC_ASSERT_IMP(a_first_count, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[CW+IW:CW+1] == '0),
        m_axis_tdata[CW:1] == CW'(m_axis_tdata[0]))

    // a saturated error never passes its limit
    `BRIC_ASSERT_IMP(a_inlier_err, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0],
        (m_axis_tdata[CW+IW+32:CW+IW+1] != ERR_SAT)
        && (m_axis_tdata[CW+IW+64:CW+IW+33] != ERR_SAT))

endmodule

bind bidirectional_reprojection_inlier_check bric_checker #(.MAX_POINTS(MAX_POINTS)) u_chk (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the bidirectional reprojection inlier check: table, random and pressure items
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import bric_pkg::*;

    localparam int  SETTLE    = 700;
    localparam int  RUN_LIMIT = 6000000;
    localparam int  N_RANDOM  = 830;
    localparam longint ONE_Q16 = 65536;
    localparam logic signed [31:0] ONE_Q20 = 32'sd1048576;

    // input item fields, lowest first from the bottom
    typedef struct packed {
        logic [2:0]  pad;
        logic [31:0] lim2, lim1, bz, by, bx, az, ay, ax, cval;
        logic [4:0]  cidx;
    } in_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] e2, e1;
        logic [9:0]  pos;
        logic [10:0] cnt;
        logic        inl;
    } out_t;

    typedef struct {
        out_t r;
        logic last;
    } res_t;

    typedef struct {
        logic        req;
        in_t         d;
        logic        last;
        logic        fix;
        logic        inl;
        logic [31:0] e1, e2;
    } row_t;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [87:0] m_axis_tdata;
    logic i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_data;

    bidirectional_reprojection_inlier_check dut (.*);

    // predictor state
    logic [CFG_W-1:0]   cam_par [8];
    logic signed [31:0] coef_mem [NCOEF];
    logic [10:0]        run_cnt;
    logic [9:0]         run_pos;

    res_t pending_res[$];
    row_t rows[$];
    int   n_err;
    int   cyc;
    bit   hold_rx;
    bit   no_gaps;
    int   burst_left;

    // clock and cycle limit
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > RUN_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // append one row to the directed table
    function automatic void add_row(row_t r);
        rows.insert(rows.size(), r);
    endfunction

    // one row of a 3x4 transform applied to p, saturated to 32 bits
    function automatic longint tf_coord(int base, int row, longint p0, longint p1, longint p2);
        longint acc;
        acc = longint'(coef_mem[base + row * 4 + 3]) >>> 4;
        acc += (longint'(coef_mem[base + row * 4 + 0]) * p0) >>> 20;
        acc += (longint'(coef_mem[base + row * 4 + 1]) * p1) >>> 20;
        acc += (longint'(coef_mem[base + row * 4 + 2]) * p2) >>> 20;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc;
    endfunction

    function automatic logic [63:0] pix_gap(logic [30:0] f, logic [30:0] c,
                                            longint x1, longint z1, longint x2, longint z2);
        longint u, v;
        u = longint'({33'd0, c}) + (longint'({33'd0, f}) * x1) / z1;
        v = longint'({33'd0, c}) + (longint'({33'd0, f}) * x2) / z2;
        return (u >= v) ? 64'(u - v) : 64'(v - u);
    endfunction

    // squared pixel distance between p and q in one camera
    function automatic logic [31:0] sq_dist(longint p0, longint p1, longint p2,
                                            longint q0, longint q1, longint q2, int cam);
        logic [63:0] dx, dy, s;
        if (p2 <= 0 || q2 <= 0) return ERR_SAT;
        dx = pix_gap(cam_par[cam*4], cam_par[cam*4+2], p0, p2, q0, q2);
        dy = pix_gap(cam_par[cam*4+1], cam_par[cam*4+3], p1, p2, q1, q2);
        if (dx >= 64'h8000_0000 || dy >= 64'h8000_0000) return ERR_SAT;
        s = (dx * dx + dy * dy) >> 16;
        return (s > 64'hFFFF_FFFF) ? ERR_SAT : s[31:0];
    endfunction

    // update the predictor with one accepted item; queue the result of a point
    task automatic predict_item(logic req, in_t d, logic last);
        longint a0, a1, a2, b0, b1, b2;
        res_t   x;
        logic   fin;
        if (req == REQ_LOAD) begin
            if (d.cidx < NCOEF) coef_mem[d.cidx] = d.cval;
            return;
        end
        a0 = longint'(signed'(d.ax)); a1 = longint'(signed'(d.ay)); a2 = longint'(signed'(d.az));
        b0 = longint'(signed'(d.bx)); b1 = longint'(signed'(d.by)); b2 = longint'(signed'(d.bz));
        x.r = '0;
        x.r.e1 = sq_dist(a0, a1, a2, tf_coord(0, 0, b0, b1, b2), tf_coord(0, 1, b0, b1, b2),
                         tf_coord(0, 2, b0, b1, b2), 0);
        x.r.e2 = sq_dist(b0, b1, b2, tf_coord(INV_BASE, 0, a0, a1, a2),
                         tf_coord(INV_BASE, 1, a0, a1, a2), tf_coord(INV_BASE, 2, a0, a1, a2), 1);
        x.r.inl = (x.r.e1 < d.lim1) && (x.r.e2 < d.lim2);
        x.r.cnt = run_cnt + 11'(x.r.inl);
        x.r.pos = run_pos;
        fin = last || (run_pos >= 10'(MAX_POINTS_DEF - 1));
        x.last = fin;
        pending_res.insert(pending_res.size(), x);
        run_cnt = fin ? '0 : x.r.cnt;
        run_pos = fin ? '0 : run_pos + 10'd1;
    endtask

    // offer one item in bursts; called and returns at a falling edge
    task automatic put_item(logic req, in_t d, logic last);
        if (!no_gaps && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tlast  <= last;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(req, d, last);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write all eight camera registers while the block is idle
    task automatic set_cameras(logic [CFG_W-1:0] v [8]);
        t_cfg_reg k;
        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        for (int i = 0; i < 8; i++) begin
            k = t_cfg_reg'(i);
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= k;
            i_cfg_data <= v[i];
            cam_par[i] = v[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic in_t mk_point(longint ax, ay, az, bx, by, bz, logic [31:0] l1, l2);
        in_t d;
        d = '0;
        d.ax = ax[31:0]; d.ay = ay[31:0]; d.az = az[31:0];
        d.bx = bx[31:0]; d.by = by[31:0]; d.bz = bz[31:0];
        d.lim1 = l1; d.lim2 = l2;
        d.cidx = 5'($urandom); d.cval = $urandom;
        return d;
    endfunction

    function automatic in_t mk_load(int k, logic [31:0] v);
        in_t d;
        d = in_t'(IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom}));
        d.pad = '0;
        d.cidx = 5'(k);
        d.cval = v;
        return d;
    endfunction

    function automatic row_t row(logic req, in_t d, logic last);
        row_t r;
        r.req = req; r.d = d; r.last = last;
        r.fix = 1'b0; r.inl = 1'b0; r.e1 = '0; r.e2 = '0;
        return r;
    endfunction

    function automatic row_t fixed(row_t r, logic inl, logic [31:0] e1, e2);
        r.fix = 1'b1; r.inl = inl; r.e1 = e1; r.e2 = e2;
        return r;
    endfunction

    // random item: mostly near-consistent correspondences, some noise and loads
    task automatic random_item();
        longint ax, ay, az, sh;
        int     k;
        in_t    d;
        k = $urandom_range(0, 19);
        if (k == 0) begin
            put_item(REQ_LOAD, mk_load($urandom_range(0, 31), $urandom), 1'b0);
        end else if (k <= 2) begin
            // near-identity coefficient, translation or rotation term
            k = $urandom_range(0, 23);
            if (k % 4 == 3 || (k % 12) / 4 != (k % 4))
                put_item(REQ_LOAD, mk_load(k, 32'($signed($urandom_range(0, 4096)) - 2048)), 1'b0);
            else
                put_item(REQ_LOAD, mk_load(k, ONE_Q20 + $signed($urandom_range(0, 2048)) - 1024),
                         1'b0);
        end else if (k == 3) begin
            d = mk_point(0, 0, 0, 0, 0, 0, 0, 0);
            d.ax = $urandom; d.ay = $urandom; d.az = $urandom;
            d.bx = $urandom; d.by = $urandom; d.bz = $urandom;
            d.lim1 = $urandom; d.lim2 = $urandom;
            put_item(REQ_POINT, d, $urandom_range(0, 40) == 0);
        end else begin
            az = longint'($urandom_range(1, 200)) * ONE_Q16 + $urandom_range(0, 65535);
            ax = longint'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
            ay = longint'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
            if ($urandom_range(0, 9) == 0) az = -az;
            sh = $urandom_range(0, 20);
            d = mk_point(ax, ay, az,
                         ax + longint'($urandom_range(0, 1 << sh)) - (1 << (sh - 1 > 0 ? sh - 1 : 0)),
                         ay + longint'($urandom_range(0, 1 << sh)) - (1 << (sh - 1 > 0 ? sh - 1 : 0)),
                         az + longint'($urandom_range(0, 1 << sh)) - (1 << (sh - 1 > 0 ? sh - 1 : 0)),
                         $urandom_range(0, 1) ? $urandom_range(0, 32'h0010_0000) : $urandom,
                         $urandom_range(0, 1) ? $urandom_range(0, 32'h0010_0000) : $urandom);
            put_item(REQ_POINT, d, $urandom_range(0, 40) == 0);
        end
    endtask

    // receiver: random stalls with calm stretches, and one long hold on request
    initial begin
        int mode_left;
        bit calm;
        m_axis_tready = 1'b0;
        mode_left = 0;
        calm = 0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (6000) @(negedge i_clk);
                hold_rx = 0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(50, 400);
                    calm = $urandom_range(0, 2) == 0;
                end
                mode_left--;
                m_axis_tready <= calm || ($urandom_range(0, 3) != 0);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        res_t x;
        out_t y;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            y = m_axis_tdata;
            if (pending_res.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                n_err++;
            end else begin
                x = pending_res.pop_front();
                if (y.inl !== x.r.inl) begin
                    $error("is_inlier exp %0d got %0d", x.r.inl, y.inl); n_err++;
                end
                if (y.cnt !== x.r.cnt) begin
                    $error("inlier_count exp %0d got %0d", x.r.cnt, y.cnt); n_err++;
                end
                if (y.pos !== x.r.pos) begin
                    $error("point_number exp %0d got %0d", x.r.pos, y.pos); n_err++;
                end
                if (y.e1 !== x.r.e1) begin
                    $error("err_img1 exp %h got %h", x.r.e1, y.e1); n_err++;
                end
                if (y.e2 !== x.r.e2) begin
                    $error("err_img2 exp %h got %h", x.r.e2, y.e2); n_err++;
                end
                if (m_axis_tlast !== x.last) begin
                    $error("batch_end exp %0d got %0d", x.last, m_axis_tlast); n_err++;
                end
            end
        end
    end

    // main sequence
    initial begin
        logic [CFG_W-1:0] cams [8];
        longint p;
        n_err = 0; cyc = 0; hold_rx = 0; no_gaps = 0; burst_left = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tuser = 1'b0; s_axis_tlast = 1'b0; s_axis_tdata = '0;
        i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_data = '0;
        cam_par = '{FOCAL_RST, FOCAL_RST, CENTER_X_RST, CENTER_Y_RST,
                    FOCAL_RST, FOCAL_RST, CENTER_X_RST, CENTER_Y_RST};
        foreach (coef_mem[i]) coef_mem[i] = '0;
        run_cnt = '0; run_pos = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        p = ONE_Q16;
        // empty bank after reset: transformed depth is zero
        add_row(fixed(row(REQ_POINT, mk_point(p, 2*p, 4*p, p, 2*p, 4*p, '1, '1), 1'b0),
                      1'b0, ERR_SAT, ERR_SAT));
        // identity both ways
        add_row(row(REQ_LOAD, mk_load(0, ONE_Q20), 1'b0));
        add_row(row(REQ_LOAD, mk_load(5, ONE_Q20), 1'b0));
        add_row(row(REQ_LOAD, mk_load(10, ONE_Q20), 1'b0));
        add_row(row(REQ_LOAD, mk_load(12, ONE_Q20), 1'b0));
        add_row(row(REQ_LOAD, mk_load(17, ONE_Q20), 1'b0));
        add_row(row(REQ_LOAD, mk_load(22, ONE_Q20), 1'b0));
        // slot beyond the bank is dropped
        add_row(row(REQ_LOAD, mk_load(31, 32'h8000_0000), 1'b0));
        add_row(row(REQ_LOAD, mk_load(24, 32'h7FFF_FFFF), 1'b0));
        // exact match: inlier unless the limit is zero
        add_row(fixed(row(REQ_POINT, mk_point(p, 2*p, 4*p, p, 2*p, 4*p, 1, 1), 1'b0),
                      1'b1, 0, 0));
        add_row(fixed(row(REQ_POINT, mk_point(p, 2*p, 4*p, p, 2*p, 4*p, 0, '1), 1'b0),
                      1'b0, 0, 0));
        // zero and negative depth
        add_row(fixed(row(REQ_POINT, mk_point(p, p, 0, p, p, p, '1, '1), 1'b0),
                      1'b0, ERR_SAT, ERR_SAT));
        add_row(fixed(row(REQ_POINT, mk_point(p, p, p, p, p, -p, '1, '1), 1'b0),
                      1'b0, ERR_SAT, ERR_SAT));
        add_row(fixed(row(REQ_POINT, mk_point(0, 0, 32'h8000_0000, 0, 0, 1, '1, '1), 1'b0),
                      1'b0, ERR_SAT, ERR_SAT));
        // coordinate extremes
        add_row(row(REQ_POINT, mk_point(32'sh7FFF_FFFF, -32'sh8000_0000, 1,
                                        -32'sh8000_0000, 32'sh7FFF_FFFF, 1, '1, '1), 1'b0));
        add_row(row(REQ_POINT, mk_point(3*p, -p, 32'sh7FFF_FFFF,
                                        3*p + 5, -p - 7, 32'sh7FFF_FFFF, '1, '1), 1'b1));
        // translation extremes, then back to zero
        add_row(row(REQ_LOAD, mk_load(3, 32'h8000_0000), 1'b0));
        add_row(row(REQ_LOAD, mk_load(23, 32'h7FFF_FFFF), 1'b0));
        add_row(row(REQ_POINT, mk_point(p, p, 8*p, p, p, 8*p, '1, '1), 1'b0));
        add_row(row(REQ_LOAD, mk_load(3, 0), 1'b0));
        add_row(row(REQ_LOAD, mk_load(23, 0), 1'b0));
        add_row(row(REQ_POINT, mk_point(2*p, p, 3*p, 2*p + 99, p, 3*p, 32'h0100_0000,
                                        32'h0100_0000), 1'b1));
        foreach (rows[i]) begin
            put_item(rows[i].req, rows[i].d, rows[i].last);
            if (rows[i].fix) begin
                pending_res[$].r.inl = rows[i].inl;
                pending_res[$].r.e1  = rows[i].e1;
                pending_res[$].r.e2  = rows[i].e2;
            end
        end

        // register extremes: everything at the top, then everything at zero
        foreach (cams[i]) cams[i] = '1;
        set_cameras(cams);
        repeat (50) random_item();
        foreach (cams[i]) cams[i] = '0;
        set_cameras(cams);
        repeat (50) random_item();

        // ordinary cameras for the bulk of the run
        for (int i = 0; i < 2; i++) begin
            cams[i*4]   = 31'($urandom_range(100, 2000)) << 16;
            cams[i*4+1] = 31'($urandom_range(100, 2000)) << 16;
            cams[i*4+2] = 31'($urandom_range(0, 1000)) << 16;
            cams[i*4+3] = 31'($urandom_range(0, 1000)) << 16;
        end
        set_cameras(cams);
        for (int i = 0; i < N_RANDOM - 100; i++) begin
            if (i == 300) begin
                // long receiver hold while items keep coming, then wait for all
                hold_rx = 1;
                no_gaps = 1;
                repeat (12) random_item();
                no_gaps = 0;
                drain_results();
            end
            random_item();
        end

        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        if (pending_res.size() != 0) begin
            $error("%0d results never arrived", pending_res.size());
            n_err++;
        end
        if (n_err == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
`default_nettype wire
